[hw/rtl/olc_pkg.sv]
// ----------------------------------------------------------------------------
// olc_pkg
// Shared types and constants for the ordered list with cursor.
// ----------------------------------------------------------------------------
package olc_pkg;

   localparam int unsigned DEPTH_DEFAULT      = 16;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   localparam int unsigned KIND_W     = 3;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned HANDOVER_W = 2;
   localparam int unsigned STATUS_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK   = 3'd0,
      KIND_REMOVE_AT   = 3'd1,
      KIND_GET_AT      = 3'd2,
      KIND_CURSOR_NEXT = 3'd3,
      KIND_CURSOR_PREV = 3'd4
   } kind_type;

   // unused code, behaves as none
   typedef enum logic [HANDOVER_W-1:0] {
      HANDOVER_NONE = 2'd0,
      HANDOVER_PREV = 2'd1,
      HANDOVER_NEXT = 2'd2,
      HANDOVER_RSVD = 2'd3
   } handover_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

endpackage

[hw/rtl/ordered_list_with_cursor.sv]
// ----------------------------------------------------------------------------
// ordered_list_with_cursor
// Ordered list of up to DEPTH words in registers, with one optional cursor.
// ----------------------------------------------------------------------------
// Request channel (req_): one operation per request. req_tuser carries the
// kind (push_back, remove_at, get_at, cursor_next, cursor_prev); req_tdata
// carries the data word, make_active, position and handover.
// Response channel (rsp_): exactly one response per request, in order.
// rsp_tuser carries the status; rsp_tdata carries the removed or read word,
// the entry count and the cursor after the operation.
// A request accepted at one edge is captured in the input register, processed
// from there and written to the response register, where rsp_tvalid rises.
// Throughput: one request per cycle while the response is taken; the list
// state is updated at the edge that writes the response register, and a
// removal shifts all later entries down in parallel.
// Reset clears the count and the cursor; the entry registers keep their
// contents and are never read before written.
// When rsp_tready is low the response register holds, the input register
// fills, and req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module ordered_list_with_cursor #(
   parameter int unsigned DEPTH      = olc_pkg::DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = olc_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
   localparam int unsigned IDX_W     = $clog2(DEPTH),
   localparam int unsigned REQ_BITS  = DATA_WIDTH + 1 + olc_pkg::POS_W
                                       + olc_pkg::HANDOVER_W,
   localparam int unsigned REQ_TDW   = ((REQ_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_BITS  = DATA_WIDTH + CNT_W + 1 + IDX_W,
   localparam int unsigned RSP_TDW   = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // data_in, make_active, position, handover
   input  logic [REQ_TDW-1:0]            req_tdata,
   // kind
   input  logic [olc_pkg::KIND_W-1:0]    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // data_out, entry_count, cursor_valid, cursor_index
   output logic [RSP_TDW-1:0]            rsp_tdata,
   // status
   output logic [olc_pkg::STATUS_W-1:0]  rsp_tuser
);

   localparam int unsigned MK_LSB   = DATA_WIDTH;
   localparam int unsigned POS_LSB  = DATA_WIDTH + 1;
   localparam int unsigned HAND_LSB = POS_LSB + olc_pkg::POS_W;

   // input register
   logic                             in_valid_ff, in_valid_in;
   logic [olc_pkg::KIND_W-1:0]       kind_ff;
   logic [DATA_WIDTH-1:0]            data_ff;
   logic                             mk_ff;
   logic [olc_pkg::POS_W-1:0]        pos_ff;
   logic [olc_pkg::HANDOVER_W-1:0]   hand_ff;

   // list state
   logic [DATA_WIDTH-1:0]            entries_ff [DEPTH];
   logic [CNT_W-1:0]                 occ_ff, occ_in;
   logic                             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]                 cur_pos_ff, cur_pos_in;

   // response register
   logic                             out_valid_ff, out_valid_in;
   logic [olc_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [DATA_WIDTH-1:0]            dout_ff, dout_in;

   logic                             advance;
   logic                             push_wr;
   logic                             remove_wr;
   logic                             pos_ok;
   logic [IDX_W-1:0]                 pos_idx;
   logic [CNT_W-1:0]                 occ_dec;
   logic [CNT_W-1:0]                 cur_inc;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign pos_ok  = pos_ff < olc_pkg::POS_W'(occ_ff);
   assign pos_idx = pos_ff[IDX_W-1:0];
   assign occ_dec = occ_ff - CNT_W'(1);
   assign cur_inc = CNT_W'(cur_pos_ff) + CNT_W'(1);

   always_comb begin
      occ_in       = occ_ff;
      cur_valid_in = cur_valid_ff;
      cur_pos_in   = cur_pos_ff;
      status_in    = olc_pkg::STATUS_OK;
      dout_in      = '0;
      push_wr      = 1'b0;
      remove_wr    = 1'b0;
      case (olc_pkg::kind_type'(kind_ff))
         olc_pkg::KIND_PUSH_BACK: begin
            if (occ_ff >= CNT_W'(DEPTH)) begin
               status_in = olc_pkg::STATUS_FULL;
            end else begin
               push_wr = 1'b1;
               occ_in  = occ_ff + CNT_W'(1);
               if (mk_ff) begin
                  cur_valid_in = 1'b1;
                  cur_pos_in   = IDX_W'(occ_ff);
               end
            end
         end
         olc_pkg::KIND_REMOVE_AT: begin
            if (!pos_ok) begin
               status_in = olc_pkg::STATUS_NOT_FOUND;
            end else begin
               remove_wr = 1'b1;
               dout_in   = entries_ff[pos_idx];
               occ_in    = occ_dec;
               if (cur_valid_ff) begin
                  if (cur_pos_ff > pos_idx) begin
                     cur_pos_in = cur_pos_ff - IDX_W'(1);
                  end else if (cur_pos_ff == pos_idx) begin
                     if (occ_dec == '0 || hand_ff == olc_pkg::HANDOVER_NONE
                         || hand_ff == olc_pkg::HANDOVER_RSVD) begin
                        cur_valid_in = 1'b0;
                        cur_pos_in   = '0;
                     end else if (hand_ff == olc_pkg::HANDOVER_PREV) begin
                        cur_pos_in = (pos_idx != '0) ? pos_idx - IDX_W'(1) : pos_idx;
                     end else begin
                        cur_pos_in = (CNT_W'(pos_idx) < occ_dec) ? pos_idx
                                                                 : pos_idx - IDX_W'(1);
                     end
                  end
               end
            end
         end
         olc_pkg::KIND_GET_AT: begin
            if (!pos_ok) begin
               status_in = olc_pkg::STATUS_NOT_FOUND;
            end else begin
               dout_in = entries_ff[pos_idx];
            end
         end
         olc_pkg::KIND_CURSOR_NEXT: begin
            if (cur_valid_ff && occ_ff != '0) begin
               cur_pos_in = (cur_inc >= occ_ff) ? '0 : IDX_W'(cur_inc);
            end
         end
         olc_pkg::KIND_CURSOR_PREV: begin
            if (cur_valid_ff && occ_ff != '0) begin
               cur_pos_in = (cur_pos_ff == '0) ? IDX_W'(occ_dec) : cur_pos_ff - IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         occ_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_pos_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            occ_ff       <= occ_in;
            cur_valid_ff <= cur_valid_in;
            cur_pos_ff   <= cur_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         data_ff <= req_tdata[DATA_WIDTH-1:0];
         mk_ff   <= req_tdata[MK_LSB];
         pos_ff  <= req_tdata[POS_LSB +: olc_pkg::POS_W];
         hand_ff <= req_tdata[HAND_LSB +: olc_pkg::HANDOVER_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         dout_ff   <= dout_in;
      end
   end

   // push writes the tail; remove shifts every later entry down one place
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (push_wr && occ_ff == CNT_W'(i)) begin
               entries_ff[i] <= data_ff;
            end
         end
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (remove_wr && pos_idx <= IDX_W'(i)) begin
               entries_ff[i] <= entries_ff[i+1];
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_TDW'({(cur_valid_ff ? cur_pos_ff : IDX_W'(0)),
                                 cur_valid_ff, occ_ff, dout_ff});

endmodule

[hw/rtl/olc_checker.sv]
// ----------------------------------------------------------------------------
// olc_checker
// Port-level checks on the ordered list with cursor, bound to the top level.
// ----------------------------------------------------------------------------
module olc_checker #(
   parameter int unsigned DEPTH      = olc_pkg::DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = olc_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
   localparam int unsigned IDX_W     = $clog2(DEPTH),
   localparam int unsigned RSP_BITS  = DATA_WIDTH + CNT_W + 1 + IDX_W,
   localparam int unsigned RSP_TDW   = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [RSP_TDW-1:0]            rsp_tdata,
   input logic [olc_pkg::STATUS_W-1:0]  rsp_tuser
);

   localparam int unsigned CNT_LSB = DATA_WIDTH;
   localparam int unsigned CV_LSB  = DATA_WIDTH + CNT_W;
   localparam int unsigned CI_LSB  = CV_LSB + 1;

   logic [CNT_W-1:0] count;
   logic             cur_v;
   logic [IDX_W-1:0] cur_i;

   assign count = rsp_tdata[CNT_LSB +: CNT_W];
   assign cur_v = rsp_tdata[CV_LSB];
   assign cur_i = rsp_tdata[CI_LSB +: IDX_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == olc_pkg::STATUS_FULL |-> count == CNT_W'(DEPTH))
      else $error("full reported with free entries");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cur_v |-> CNT_W'(cur_i) < count)
      else $error("cursor beyond last entry");

   a_cursor_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !cur_v |-> cur_i == '0)
      else $error("cursor index set without active entry");

endmodule

bind ordered_list_with_cursor olc_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_olc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_list_with_cursor. A short table of list
// operations runs first, some rows carrying hand-written responses, then
// random operation streams that alternate between growing and shrinking the
// list. Each accepted request is run through a behavioral list model and the
// responses are compared in order, field by field, under four mixes of
// sender idling and receiver backpressure.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH       = olc_pkg::DEPTH_DEFAULT;
   localparam int unsigned DW          = olc_pkg::DATA_WIDTH_DEFAULT;
   localparam int unsigned REQ_TDW     = ((DW + 1 + olc_pkg::POS_W + olc_pkg::HANDOVER_W + 7)
                                          / 8) * 8;
   localparam int unsigned RSP_TDW     = ((DW + 5 + 1 + 4 + 7) / 8) * 8;
   localparam int          CLK_PERIOD  = 8;
   localparam int          RSP_LATENCY = 2;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          PHASE_OPS   = 200;

   localparam logic [olc_pkg::KIND_W-1:0] KIND_RSVD5 = 3'd5;
   localparam logic [olc_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
   localparam logic [olc_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;

   typedef struct packed {
      logic [olc_pkg::KIND_W-1:0]     kind;
      logic [DW-1:0]                  word;
      logic                           mark;
      logic [olc_pkg::POS_W-1:0]      pos;
      logic [olc_pkg::HANDOVER_W-1:0] hand;
   } list_op_type;

   typedef struct packed {
      logic [olc_pkg::STATUS_W-1:0] status;
      logic [DW-1:0]                word;
      logic [4:0]                   count;
      logic                         cur_valid;
      logic [3:0]                   cur_index;
   } list_rsp_type;

   typedef struct packed {
      list_op_type  op;
      logic         pinned;
      list_rsp_type rsp;
   } table_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [REQ_TDW-1:0]           req_tdata;
   logic [olc_pkg::KIND_W-1:0]   req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [RSP_TDW-1:0]           rsp_tdata;
   logic [olc_pkg::STATUS_W-1:0] rsp_tuser;

   // list model state
   logic [DW-1:0] list_words [DEPTH];
   int            list_len;
   bit            cursor_on;
   int            cursor_at;

   list_rsp_type  replies_due [$];
   bit            pin_pending;
   list_rsp_type  pinned_rsp;
   bit            req_fire;
   int            send_idle_pct;
   int            stall_pct;
   int            rsp_holdoff;
   int            mismatches;
   int            cycles;
   int            replies_seen;

   table_row_type opening_ops [26] = '{
      '{'{olc_pkg::KIND_GET_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_NOT_FOUND, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_NOT_FOUND, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{olc_pkg::KIND_CURSOR_NEXT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{olc_pkg::KIND_CURSOR_PREV, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{KIND_RSVD5, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'hFFFFFFFF, 1'b1, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd1, 1'b1, 4'd0}},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'h00000000, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd2, 1'b1, 4'd0}},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'hA5A5A5A5, 1'b1, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd3, 1'b1, 4'd2}},
      '{'{olc_pkg::KIND_CURSOR_NEXT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_CURSOR_PREV, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_GET_AT, 32'h0, 1'b0, 8'd255, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_NOT_FOUND, 32'h0, 5'd3, 1'b1, 4'd2}},
      '{'{olc_pkg::KIND_GET_AT, 32'h0, 1'b0, 8'd3, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_GET_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd1, olc_pkg::HANDOVER_NEXT}, 1'b0, '0},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'h12345678, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_PREV}, 1'b0, '0},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'hDEADBEEF, 1'b1, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd1, olc_pkg::HANDOVER_RSVD}, 1'b0, '0},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'h5A5A5A5A, 1'b1, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd1, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_PUSH_BACK, 32'h0F0F0F0F, 1'b1, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_PREV}, 1'b0, '0},
      '{'{olc_pkg::KIND_REMOVE_AT, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NEXT}, 1'b0, '0},
      '{'{KIND_RSVD7, 32'h0, 1'b0, 8'd0, olc_pkg::HANDOVER_NONE}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd0, 1'b0, 4'd0}},
      '{'{KIND_RSVD6, 32'hFFFFFFFF, 1'b1, 8'd255, olc_pkg::HANDOVER_RSVD}, 1'b1,
        '{olc_pkg::STATUS_OK, 32'h0, 5'd0, 1'b0, 4'd0}}
   };

   ordered_list_with_cursor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic list_rsp_type apply_list_op(list_op_type op);
      list_rsp_type r;
      int           p;
      int           i;
      r = '0;
      p = op.pos;
      case (op.kind)
         olc_pkg::KIND_PUSH_BACK: begin
            if (list_len >= DEPTH) begin
               r.status = olc_pkg::STATUS_FULL;
            end else begin
               list_words[list_len] = op.word;
               if (op.mark) begin
                  cursor_on = 1'b1;
                  cursor_at = list_len;
               end
               list_len++;
            end
         end
         olc_pkg::KIND_REMOVE_AT: begin
            if (p >= list_len) begin
               r.status = olc_pkg::STATUS_NOT_FOUND;
            end else begin
               r.word = list_words[p];
               for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
               list_len--;
               if (cursor_on && cursor_at > p) begin
                  cursor_at--;
               end else if (cursor_on && cursor_at == p) begin
                  if (list_len == 0 || op.hand == olc_pkg::HANDOVER_NONE
                      || op.hand == olc_pkg::HANDOVER_RSVD) begin
                     cursor_on = 1'b0;
                     cursor_at = 0;
                  end else if (op.hand == olc_pkg::HANDOVER_PREV) begin
                     cursor_at = (p > 0) ? p - 1 : p;
                  end else begin
                     cursor_at = (p < list_len) ? p : p - 1;
                  end
               end
            end
         end
         olc_pkg::KIND_GET_AT: begin
            if (p >= list_len) r.status = olc_pkg::STATUS_NOT_FOUND;
            else r.word = list_words[p];
         end
         olc_pkg::KIND_CURSOR_NEXT: begin
            if (cursor_on && list_len > 0) begin
               cursor_at = (cursor_at + 1 >= list_len) ? 0 : cursor_at + 1;
            end
         end
         olc_pkg::KIND_CURSOR_PREV: begin
            if (cursor_on && list_len > 0) begin
               cursor_at = (cursor_at == 0) ? list_len - 1 : cursor_at - 1;
            end
         end
         default: ;
      endcase
      r.count     = 5'(list_len);
      r.cur_valid = cursor_on;
      r.cur_index = cursor_on ? 4'(cursor_at) : 4'd0;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 100) $display("MISMATCH cycle %0d response %0d: %s", cycles, replies_seen, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      list_op_type  op;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            if (rsp_tvalid && rsp_tready) begin
               got = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[36:32], rsp_tdata[37],
                       rsp_tdata[41:38]};
               if (replies_due.size() == 0) begin
                  report_mismatch("response with no request outstanding");
               end else begin
                  want = replies_due.pop_front();
                  if (got.status !== want.status)
                     report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                  if (got.word !== want.word)
                     report_mismatch($sformatf("data_out %h, want %h", got.word, want.word));
                  if (got.count !== want.count)
                     report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
                  if (got.cur_valid !== want.cur_valid)
                     report_mismatch($sformatf("cursor_valid %b, want %b",
                                               got.cur_valid, want.cur_valid));
                  if (got.cur_index !== want.cur_index)
                     report_mismatch($sformatf("cursor_index %0d, want %0d",
                                               got.cur_index, want.cur_index));
               end
               replies_seen++;
            end
            req_fire = req_tvalid && req_tready;
            if (req_fire) begin
               op   = '{req_tuser, req_tdata[31:0], req_tdata[32], req_tdata[40:33],
                        req_tdata[42:41]};
               want = apply_list_op(op);
               if (pin_pending) begin
                  want        = pinned_rsp;
                  pin_pending = 1'b0;
               end
               replies_due.push_back(want);
            end
         end
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_tready = 1'b0;
            rsp_holdoff--;
         end else begin
            rsp_tready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_list_op(list_op_type op, bit pin, list_rsp_type pin_val);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_pending = pin;
      pinned_rsp  = pin_val;
      req_tuser   = op.kind;
      req_tdata   = REQ_TDW'({op.hand, op.pos, op.mark, op.word});
      req_tvalid  = 1'b1;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic wait_replies_done();
      req_tvalid = 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   function automatic list_op_type random_list_op(bit grow);
      list_op_type op;
      int          roll;
      int          pick;
      op.word = $urandom;
      op.mark = ($urandom_range(99) < 40);
      op.hand = ($urandom_range(99) < 5) ? olc_pkg::HANDOVER_RSVD
                                         : 2'($urandom_range(olc_pkg::HANDOVER_NEXT));
      pick = $urandom_range(99);
      if (list_len > 0 && pick < 80) op.pos = 8'($urandom_range(list_len - 1));
      else if (pick < 90) op.pos = 8'(list_len);
      else op.pos = 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 3) op.kind = 3'($urandom_range(KIND_RSVD7, KIND_RSVD5));
      else if (roll < (grow ? 58 : 18)) op.kind = olc_pkg::KIND_PUSH_BACK;
      else if (roll < 73) op.kind = grow ? olc_pkg::KIND_REMOVE_AT : olc_pkg::KIND_GET_AT;
      else if (roll < 82) op.kind = olc_pkg::KIND_CURSOR_NEXT;
      else if (roll < 91) op.kind = olc_pkg::KIND_CURSOR_PREV;
      else op.kind = grow ? olc_pkg::KIND_GET_AT : olc_pkg::KIND_REMOVE_AT;
      // shrinking mode: fold the upper part of the get share into removes
      if (!grow && roll >= 58 && roll < 73) op.kind = olc_pkg::KIND_REMOVE_AT;
      return op;
   endfunction

   initial begin
      int          idle_plan [4];
      int          stall_plan [4];
      int          ph;
      int          n_ops;
      bit          grow;
      list_op_type op;
      idle_plan     = '{0, 78, 0, 33};
      stall_plan    = '{0, 0, 78, 33};
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = olc_pkg::KIND_PUSH_BACK;
      send_idle_pct = 0;
      stall_pct     = 0;
      rsp_holdoff   = 0;
      pin_pending   = 1'b0;
      pinned_rsp    = '0;
      req_fire      = 1'b0;
      mismatches    = 0;
      cycles        = 0;
      replies_seen  = 0;
      list_len      = 0;
      cursor_on     = 1'b0;
      cursor_at     = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (opening_ops[i]) send_list_op(opening_ops[i].op, opening_ops[i].pinned,
                                            opening_ops[i].rsp);
      wait_replies_done();

      grow = 1'b1;
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph];
         stall_pct     = stall_plan[ph];
         n_ops         = 0;
         while (n_ops < PHASE_OPS) begin
            if (list_len == DEPTH) grow = 1'b0;
            else if (list_len == 0) grow = 1'b1;
            else if ($urandom_range(99) < 2) grow = !grow;
            op = random_list_op(grow);
            if (op.kind <= olc_pkg::KIND_CURSOR_PREV) n_ops++;
            // long receiver hold-off while requests keep coming
            if (n_ops == 100 && (ph == 0 || ph == 3)) rsp_holdoff = 80;
            send_list_op(op, 1'b0, '0);
         end
         wait_replies_done();
      end

      repeat (RSP_LATENCY + 4) @(negedge clock);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
